// File: rtl/lru_page_buffer_macros.svh
// Assertion macros shared by the checkers of the page buffer.
// Needs nothing else; the clock and the active-low reset are passed in.
`ifndef LRU_PAGE_BUFFER_MACROS_SVH
`define LRU_PAGE_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru_page_buffer: port check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru_page_buffer: port check failed");

`endif

// File: rtl/lpb_pkg.sv
// Constants of the page buffer: configuration port layout and register map.
// Depends on nothing; used by the top level.
package lpb_pkg;

    localparam int unsigned CFG_W    = 5;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;

    // Register index, taken from paddr[2].
    localparam logic [0:0] REG_FRAMES_IN_USE = 1'b0;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

endpackage

// File: rtl/lru_page_buffer.sv
// Buffer pool with least-recently-used replacement over up to MAX_FRAMES frames.
// A request is held in the input register, and its result in the result register.
// Throughput: one request per cycle while i_stall is low; the recency list is
// searched and shifted combinationally between the input and result registers.
// Reset (synchronous, i_rst_n low) empties the pool, restarts the free-frame
// counter at zero and sets frames_in_use to 16. Depends on lpb_pkg.
module lru_page_buffer #(
    parameter int unsigned MAX_FRAMES    = 16,
    parameter int unsigned PAGE_ID_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // Request channel.
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [PAGE_ID_WIDTH-1:0]         i_page_number,

    // Result channel.
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_hit,
    output logic [$clog2(MAX_FRAMES)-1:0]    o_frame_number,
    output logic                             o_evicted_valid,
    output logic [PAGE_ID_WIDTH-1:0]         o_evicted_page,

    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpb_pkg::APB_AW-1:0]       paddr,
    input  logic [lpb_pkg::APB_DW-1:0]       pwdata,
    output logic [lpb_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    // Widths derived from the pool size. The count needs one more value than
    // the index, since a full pool holds MAX_FRAMES pages.
    localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
    localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned CMP_W = (CNT_W > lpb_pkg::CFG_W) ? CNT_W : lpb_pkg::CFG_W;

    // ------------------------------------------------------------------
    // Configuration register. Writes complete in the access phase; pready
    // is tied high so there are no wait states.
    // ------------------------------------------------------------------
    logic [lpb_pkg::CFG_W-1:0] r_frames_in_use;
    logic                      w_cfg_wr;
    logic                      w_cfg_sel;

    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[2] == lpb_pkg::REG_FRAMES_IN_USE);
    assign w_cfg_wr  = psel && penable && pwrite && w_cfg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= lpb_pkg::FRAMES_IN_USE_RST;
        end else if (w_cfg_wr) begin
            r_frames_in_use <= pwdata[lpb_pkg::CFG_W-1:0];
        end
    end

    // Reads of an address beyond the register map return zero.
    always_comb begin
        prdata = '0;
        if (w_cfg_sel) begin
            prdata = lpb_pkg::APB_DW'(r_frames_in_use);
        end
    end

    // ------------------------------------------------------------------
    // Input register. A request is held here while the result register is
    // occupied and stalled; otherwise it is processed in the following cycle,
    // which frees the register for the next transfer.
    // ------------------------------------------------------------------
    logic                     r_in_valid;
    logic [PAGE_ID_WIDTH-1:0] r_in_page;
    logic                     r_out_valid;
    logic                     w_fire;
    logic                     w_in_take;

    assign w_fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_fire;
    assign w_in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_page <= i_page_number;
        end
    end

    // ------------------------------------------------------------------
    // Recency list. Entry 0 is the most recently used page; only entries
    // below r_occ are meaningful. Every entry is compared with the request
    // in parallel, and the list shifts down by one up to the chosen entry
    // while the request is written at the front.
    // ------------------------------------------------------------------
    logic [PAGE_ID_WIDTH-1:0] r_slot_page  [MAX_FRAMES];
    logic [IDX_W-1:0]         r_slot_frame [MAX_FRAMES];
    logic [CNT_W-1:0]         r_occ;
    logic [IDX_W-1:0]         r_next_free;

    logic [PAGE_ID_WIDTH-1:0] n_slot_page  [MAX_FRAMES];
    logic [IDX_W-1:0]         n_slot_frame [MAX_FRAMES];
    logic [CNT_W-1:0]         n_occ;
    logic [IDX_W-1:0]         n_next_free;

    logic [CMP_W-1:0]         w_fiu_ext;
    logic [CMP_W-1:0]         w_cap_ext;
    logic [CMP_W-1:0]         w_occ_ext;
    logic                     w_hit;
    logic [IDX_W-1:0]         w_hit_idx;
    logic                     w_free;
    logic [IDX_W-1:0]         w_tail_idx;
    logic [IDX_W-1:0]         w_last;
    logic [IDX_W-1:0]         w_frame;
    logic                     w_evict;
    logic [PAGE_ID_WIDTH-1:0] w_evict_page;

    // The usable capacity: zero acts as one, and values above the pool size
    // saturate to it.
    always_comb begin
        w_fiu_ext = CMP_W'(r_frames_in_use);
        if (w_fiu_ext == '0) begin
            w_cap_ext = CMP_W'(1);
        end else if (w_fiu_ext > CMP_W'(MAX_FRAMES)) begin
            w_cap_ext = CMP_W'(MAX_FRAMES);
        end else begin
            w_cap_ext = w_fiu_ext;
        end
    end

    assign w_occ_ext = CMP_W'(r_occ);

    // Parallel tag compare. Resident pages are distinct, so at most one entry
    // matches; the scan still keeps the nearest one to the front.
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_occ) && (r_slot_page[i] == r_in_page)) begin
                w_hit     = 1'b1;
                w_hit_idx = IDX_W'(i);
            end
        end
    end

    // On an eviction the occupancy is at least one, so the tail index is
    // always a real entry when it is used.
    assign w_tail_idx   = IDX_W'(r_occ - CNT_W'(1));
    assign w_free       = !w_hit && (w_occ_ext < w_cap_ext);
    assign w_evict      = !w_hit && !w_free;
    assign w_evict_page = r_slot_page[w_tail_idx];

    always_comb begin
        if (w_hit) begin
            w_last  = w_hit_idx;
            w_frame = r_slot_frame[w_hit_idx];
        end else if (w_free) begin
            // A free fill means the pool is below its size, so r_occ fits.
            w_last  = IDX_W'(r_occ);
            w_frame = r_next_free;
        end else begin
            w_last  = w_tail_idx;
            w_frame = r_slot_frame[w_tail_idx];
        end
    end

    always_comb begin
        n_slot_page[0]  = r_in_page;
        n_slot_frame[0] = w_frame;
        for (int i = 1; i < MAX_FRAMES; i++) begin
            if (IDX_W'(i) <= w_last) begin
                n_slot_page[i]  = r_slot_page[i-1];
                n_slot_frame[i] = r_slot_frame[i-1];
            end else begin
                n_slot_page[i]  = r_slot_page[i];
                n_slot_frame[i] = r_slot_frame[i];
            end
        end
    end

    // The free-frame counter runs 0,1,2,... and wraps at the pool size.
    always_comb begin
        n_occ       = r_occ;
        n_next_free = r_next_free;
        if (w_free) begin
            n_occ = r_occ + CNT_W'(1);
            if (r_next_free == IDX_W'(MAX_FRAMES - 1)) begin
                n_next_free = '0;
            end else begin
                n_next_free = r_next_free + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_next_free <= '0;
        end else if (w_fire) begin
            r_occ       <= n_occ;
            r_next_free <= n_next_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_slot_page  <= n_slot_page;
            r_slot_frame <= n_slot_frame;
        end
    end

    // ------------------------------------------------------------------
    // Result register. It is loaded whenever a request is processed and is
    // emptied by an output transfer with no new result behind it.
    // ------------------------------------------------------------------
    logic                     r_out_hit;
    logic [IDX_W-1:0]         r_out_frame;
    logic                     r_out_evicted_valid;
    logic [PAGE_ID_WIDTH-1:0] r_out_evicted_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_hit           <= w_hit;
            r_out_frame         <= w_frame;
            r_out_evicted_valid <= w_evict;
            r_out_evicted_page  <= w_evict ? w_evict_page : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_number  = r_out_frame;
    assign o_evicted_valid = r_out_evicted_valid;
    assign o_evicted_page  = r_out_evicted_page;

endmodule

// File: rtl/lpb_chk.sv
// Port-level checker for the page buffer, bound to its top level.
// Depends on lru_page_buffer_macros.svh and on the ports of lru_page_buffer.
`include "lru_page_buffer_macros.svh"

module lpb_chk #(
    parameter int unsigned MAX_FRAMES    = 16,
    parameter int unsigned PAGE_ID_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [PAGE_ID_WIDTH-1:0]      i_page_number,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_hit,
    input logic [$clog2(MAX_FRAMES)-1:0] o_frame_number,
    input logic                          o_evicted_valid,
    input logic [PAGE_ID_WIDTH-1:0]      o_evicted_page
);

    // A hit never evicts anything.
    `LPB_ASSERT_SAME(a_hit_no_evict, i_clk, i_rst_n, o_valid && o_hit, !o_evicted_valid)

    // With no eviction the reported page is zero.
    `LPB_ASSERT_SAME(a_evict_page_zero, i_clk, i_rst_n, o_valid && !o_evicted_valid, o_evicted_page == '0)

    // A stalled result stays offered with the same frame.
    `LPB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_frame_number) && $stable(o_hit))

    // A stalled request keeps its page number.
    `LPB_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, $stable(i_page_number))

endmodule

bind lru_page_buffer lpb_chk #(
    .MAX_FRAMES    (MAX_FRAMES),
    .PAGE_ID_WIDTH (PAGE_ID_WIDTH)
) u_lpb_chk (.*);
